>>> rtl/core/sdlc_pkg.sv
// ----------------------------------------------------------------------------
// sdlc_pkg
// Shared constants for the segment distance line coverage unit.
// ----------------------------------------------------------------------------
package sdlc_pkg;

  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned WidthBits        = 12;
  localparam int unsigned DistBits         = 20;   // saturated distance, 1/256 px
  localparam int unsigned DistFrac         = 8;    // fraction bits of the distance
  localparam int unsigned CovBits          = 9;
  localparam int unsigned AaHalf           = 128;
  localparam int unsigned CovFull          = 256;
  localparam int unsigned CfgIdxBits       = 3;

  localparam logic [WidthBits-1:0] LineWidthReset = WidthBits'(1);

  // register indexes of the configuration port
  localparam logic [CfgIdxBits-1:0] CfgStartX    = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgStartY    = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgEndX      = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgEndY      = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgLineWidth = 3'd4;

endpackage

>>> rtl/core/segment_distance_line_coverage.sv
// ----------------------------------------------------------------------------
// segment_distance_line_coverage
// Antialiased thick-segment coverage: pixel distance to a segment, coverage
// ramp and alpha scaling, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline depth is set by the bit-per-stage square root and the
//   20-stage bit-per-stage divider.
// Throughput: one word per cycle while the output is not stalled.
// Reset: pipeline valid bits clear, endpoints reset to 0, line width to 1.
// ----------------------------------------------------------------------------
module segment_distance_line_coverage
  import sdlc_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [CfgIdxBits-1:0]               cfg_idx_i,
  input  logic [((COORD_BITS > WidthBits) ? COORD_BITS : WidthBits)-1:0] cfg_data_i,
  // pixel input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_BITS-1:0]        pixel_x_i,
  input  logic signed [COORD_BITS-1:0]        pixel_y_i,
  input  logic [31:0]                         source_color_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                draw_o,
  output logic [CovBits-1:0]                  coverage_o,
  output logic [31:0]                         shaded_color_o
);

  localparam int unsigned DW  = COORD_BITS + 1;   // coordinate difference
  localparam int unsigned PW  = 2 * DW;           // products, squared lengths
  localparam int unsigned RW  = DW;               // square root
  localparam int unsigned EW  = RW + DistBits;    // distance saturation check
  localparam int unsigned QB  = DistBits;         // divider quotient bits
  localparam logic [DistBits-1:0] DistMax = '1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic [WidthBits-1:0]         line_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q    <= '0;
      start_y_q    <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      line_width_q <= LineWidthReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartX:    start_x_q    <= cfg_data_i[COORD_BITS-1:0];
        CfgStartY:    start_y_q    <= cfg_data_i[COORD_BITS-1:0];
        CfgEndX:      end_x_q      <= cfg_data_i[COORD_BITS-1:0];
        CfgEndY:      end_y_q      <= cfg_data_i[COORD_BITS-1:0];
        CfgLineWidth: line_width_q <= cfg_data_i[WidthBits-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Global pipeline advance: the whole pipe holds while a finished word
  // waits at a stalled output.
  // --------------------------------------------------------------------------
  logic adv;
  logic out_vld_q;

  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // Stage 1: coordinate differences
  // --------------------------------------------------------------------------
  logic              s1_vld_q;
  logic signed [DW-1:0] s1_apx_q, s1_apy_q, s1_bpx_q, s1_bpy_q, s1_abx_q, s1_aby_q;
  logic [31:0]       s1_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_apx_q   <= DW'(pixel_x_i) - DW'(start_x_q);
      s1_apy_q   <= DW'(pixel_y_i) - DW'(start_y_q);
      s1_bpx_q   <= DW'(pixel_x_i) - DW'(end_x_q);
      s1_bpy_q   <= DW'(pixel_y_i) - DW'(end_y_q);
      s1_abx_q   <= DW'(end_x_q) - DW'(start_x_q);
      s1_aby_q   <= DW'(end_y_q) - DW'(start_y_q);
      s1_color_q <= source_color_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: products (one multiplier per term, all in parallel)
  // --------------------------------------------------------------------------
  logic              s2_vld_q;
  logic signed [PW-1:0] s2_dot_x_q, s2_dot_y_q, s2_apx2_q, s2_apy2_q, s2_bpx2_q, s2_bpy2_q;
  logic signed [PW-1:0] s2_abx2_q, s2_aby2_q, s2_crs_a_q, s2_crs_b_q;
  logic [31:0]       s2_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_dot_x_q <= PW'(s1_apx_q) * PW'(s1_abx_q);
      s2_dot_y_q <= PW'(s1_apy_q) * PW'(s1_aby_q);
      s2_apx2_q  <= PW'(s1_apx_q) * PW'(s1_apx_q);
      s2_apy2_q  <= PW'(s1_apy_q) * PW'(s1_apy_q);
      s2_bpx2_q  <= PW'(s1_bpx_q) * PW'(s1_bpx_q);
      s2_bpy2_q  <= PW'(s1_bpy_q) * PW'(s1_bpy_q);
      s2_abx2_q  <= PW'(s1_abx_q) * PW'(s1_abx_q);
      s2_aby2_q  <= PW'(s1_aby_q) * PW'(s1_aby_q);
      s2_crs_a_q <= PW'(s1_abx_q) * PW'(s1_apy_q);
      s2_crs_b_q <= PW'(s1_aby_q) * PW'(s1_apx_q);
      s2_color_q <= s1_color_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: projection, region select, squared lengths, cross product.
  // Its registers are entry 0 of the square root pipes.
  // --------------------------------------------------------------------------
  logic signed [PW:0]   s3_t;
  logic [PW-1:0]        s3_l2, s3_d2a, s3_d2b, s3_d2;
  logic signed [PW-1:0] s3_crs;
  logic [PW-1:0]        s3_crs_abs;
  logic                 s3_t_pos, s3_t_ge, s3_between;

  always_comb begin
    s3_t       = (PW+1)'(s2_dot_x_q) + (PW+1)'(s2_dot_y_q);
    s3_l2      = $unsigned(s2_abx2_q) + $unsigned(s2_aby2_q);
    s3_d2a     = $unsigned(s2_apx2_q) + $unsigned(s2_apy2_q);
    s3_d2b     = $unsigned(s2_bpx2_q) + $unsigned(s2_bpy2_q);
    s3_crs     = s2_crs_a_q - s2_crs_b_q;
    s3_crs_abs = s3_crs[PW-1] ? $unsigned(-s3_crs) : $unsigned(s3_crs);
    s3_t_pos   = !s3_t[PW] && (s3_t != '0);
    s3_t_ge    = (s3_t >= $signed({1'b0, s3_l2}));
    s3_between = (s3_l2 != '0) && s3_t_pos && !s3_t_ge;
    // point case: zero-length segment, or before the first end
    if ((s3_l2 == '0) || !s3_t_pos) begin
      s3_d2 = s3_d2a;
    end else begin
      s3_d2 = s3_d2b;
    end
  end

  // square root pipes: one root bit per stage, entry j holds stage j
  logic          sq_vld_q   [0:RW];
  logic [PW-1:0] pt_n_q     [0:RW];
  logic [RW+1:0] pt_r_q     [0:RW];
  logic [RW-1:0] pt_root_q  [0:RW];
  logic [PW-1:0] ln_n_q     [0:RW];
  logic [RW+1:0] ln_r_q     [0:RW];
  logic [RW-1:0] ln_root_q  [0:RW];
  logic [PW-1:0] sq_crs_q   [0:RW];
  logic          sq_btw_q   [0:RW];
  logic [31:0]   sq_color_q [0:RW];

  logic [RW+3:0] pt_r2 [0:RW-1];
  logic [RW+3:0] pt_t  [0:RW-1];
  logic [RW+3:0] ln_r2 [0:RW-1];
  logic [RW+3:0] ln_t  [0:RW-1];

  always_comb begin
    for (int j = 0; j < RW; j++) begin
      pt_r2[j] = {pt_r_q[j], pt_n_q[j][PW-1:PW-2]};
      pt_t[j]  = (RW+4)'({pt_root_q[j], 2'b01});
      ln_r2[j] = {ln_r_q[j], ln_n_q[j][PW-1:PW-2]};
      ln_t[j]  = (RW+4)'({ln_root_q[j], 2'b01});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= RW; j++) begin
        sq_vld_q[j] <= 1'b0;
      end
    end else if (adv) begin
      sq_vld_q[0] <= s2_vld_q;
      for (int j = 0; j < RW; j++) begin
        sq_vld_q[j+1] <= sq_vld_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_n_q[0]     <= s3_d2;
      pt_r_q[0]     <= '0;
      pt_root_q[0]  <= '0;
      ln_n_q[0]     <= s3_l2;
      ln_r_q[0]     <= '0;
      ln_root_q[0]  <= '0;
      sq_crs_q[0]   <= s3_crs_abs;
      sq_btw_q[0]   <= s3_between;
      sq_color_q[0] <= s2_color_q;
      for (int j = 0; j < RW; j++) begin
        pt_n_q[j+1] <= pt_n_q[j] << 2;
        if (pt_r2[j] >= pt_t[j]) begin
          pt_r_q[j+1]    <= (RW+2)'(pt_r2[j] - pt_t[j]);
          pt_root_q[j+1] <= {pt_root_q[j][RW-2:0], 1'b1};
        end else begin
          pt_r_q[j+1]    <= (RW+2)'(pt_r2[j]);
          pt_root_q[j+1] <= {pt_root_q[j][RW-2:0], 1'b0};
        end
        ln_n_q[j+1] <= ln_n_q[j] << 2;
        if (ln_r2[j] >= ln_t[j]) begin
          ln_r_q[j+1]    <= (RW+2)'(ln_r2[j] - ln_t[j]);
          ln_root_q[j+1] <= {ln_root_q[j][RW-2:0], 1'b1};
        end else begin
          ln_r_q[j+1]    <= (RW+2)'(ln_r2[j]);
          ln_root_q[j+1] <= {ln_root_q[j][RW-2:0], 1'b0};
        end
        sq_crs_q[j+1]   <= sq_crs_q[j];
        sq_btw_q[j+1]   <= sq_btw_q[j];
        sq_color_q[j+1] <= sq_color_q[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Saturation stage: endpoint distance, divider overflow check and divider
  // seed. Its registers are entry 0 of the divider pipe.
  // --------------------------------------------------------------------------
  logic [EW-1:0]       sat_pt_ext;
  logic [DistBits-1:0] sat_pt_dist;
  logic [PW-1:0]       sat_crs_hi;
  logic                sat_div_ovf;

  always_comb begin
    sat_pt_ext  = EW'(pt_root_q[RW]) << DistFrac;
    sat_pt_dist = (sat_pt_ext > EW'(DistMax)) ? DistMax : sat_pt_ext[DistBits-1:0];
    // quotient cross*256/len reaches 2^DistBits exactly when cross>>12 >= len
    sat_crs_hi  = sq_crs_q[RW] >> (QB - DistFrac);
    sat_div_ovf = (sat_crs_hi >= PW'(ln_root_q[RW]));
  end

  logic                dv_vld_q   [0:QB];
  logic [RW:0]         dv_r_q     [0:QB];
  logic [QB-1:0]       dv_n_q     [0:QB];
  logic [QB-1:0]       dv_q_q     [0:QB];
  logic [RW-1:0]       dv_len_q   [0:QB];
  logic                dv_ovf_q   [0:QB];
  logic                dv_btw_q   [0:QB];
  logic [DistBits-1:0] dv_pt_q    [0:QB];
  logic [31:0]         dv_color_q [0:QB];

  logic [RW+1:0] dv_r2 [0:QB-1];
  logic [RW+1:0] dv_dv [0:QB-1];

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      dv_r2[j] = {dv_r_q[j], dv_n_q[j][QB-1]};
      dv_dv[j] = (RW+2)'(dv_len_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= QB; j++) begin
        dv_vld_q[j] <= 1'b0;
      end
    end else if (adv) begin
      dv_vld_q[0] <= sq_vld_q[RW];
      for (int j = 0; j < QB; j++) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_r_q[0]     <= (RW+1)'(sat_crs_hi);
      dv_n_q[0]     <= {sq_crs_q[RW][QB-DistFrac-1:0], DistFrac'(0)};
      dv_q_q[0]     <= '0;
      dv_len_q[0]   <= ln_root_q[RW];
      dv_ovf_q[0]   <= sat_div_ovf;
      dv_btw_q[0]   <= sq_btw_q[RW];
      dv_pt_q[0]    <= sat_pt_dist;
      dv_color_q[0] <= sq_color_q[RW];
      for (int j = 0; j < QB; j++) begin
        dv_n_q[j+1] <= dv_n_q[j] << 1;
        if (dv_r2[j] >= dv_dv[j]) begin
          dv_r_q[j+1] <= (RW+1)'(dv_r2[j] - dv_dv[j]);
          dv_q_q[j+1] <= {dv_q_q[j][QB-2:0], 1'b1};
        end else begin
          dv_r_q[j+1] <= (RW+1)'(dv_r2[j]);
          dv_q_q[j+1] <= {dv_q_q[j][QB-2:0], 1'b0};
        end
        dv_len_q[j+1]   <= dv_len_q[j];
        dv_ovf_q[j+1]   <= dv_ovf_q[j];
        dv_btw_q[j+1]   <= dv_btw_q[j];
        dv_pt_q[j+1]    <= dv_pt_q[j];
        dv_color_q[j+1] <= dv_color_q[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Coverage stage: pick the distance and map it onto the antialiasing ramp
  // --------------------------------------------------------------------------
  logic [DistBits-1:0] cv_dist;
  logic [DistBits:0]   cv_radius, cv_outer, cv_dist_in;
  logic                cv_hit;
  logic [CovBits-1:0]  cv_cov;

  always_comb begin
    if (dv_btw_q[QB]) begin
      cv_dist = dv_ovf_q[QB] ? DistMax : dv_q_q[QB];
    end else begin
      cv_dist = dv_pt_q[QB];
    end
    cv_radius  = (DistBits+1)'(line_width_q) << 7;
    cv_outer   = cv_radius + (DistBits+1)'(AaHalf);
    cv_dist_in = (DistBits+1)'(cv_dist) + (DistBits+1)'(AaHalf);
    cv_hit     = (line_width_q != '0) && ((DistBits+1)'(cv_dist) <= cv_outer);
    if (cv_dist_in <= cv_radius) begin
      cv_cov = CovBits'(CovFull);
    end else begin
      cv_cov = CovBits'(cv_outer - (DistBits+1)'(cv_dist));
    end
  end

  logic               cv_vld_q, cv_hit_q;
  logic [CovBits-1:0] cv_cov_q;
  logic [31:0]        cv_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_vld_q <= 1'b0;
    end else if (adv) begin
      cv_vld_q <= dv_vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cv_hit_q   <= cv_hit;
      cv_cov_q   <= cv_cov;
      cv_color_q <= dv_color_q[QB];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: scale alpha, zero everything for an undrawn pixel
  // --------------------------------------------------------------------------
  logic [7:0]         oc_alpha;
  logic [16:0]        oc_prod;
  logic               oc_draw;

  always_comb begin
    oc_alpha = cv_color_q[31:24];
    oc_prod  = 17'(oc_alpha) * 17'(cv_cov_q);
    oc_draw  = cv_hit_q && (oc_alpha != '0);
  end

  logic               draw_q;
  logic [CovBits-1:0] coverage_q;
  logic [31:0]        shaded_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= cv_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      draw_q     <= oc_draw;
      coverage_q <= oc_draw ? cv_cov_q : '0;
      shaded_q   <= oc_draw ? {oc_prod[15:8], cv_color_q[23:0]} : '0;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign draw_o         = draw_q;
  assign coverage_o     = coverage_q;
  assign shaded_color_o = shaded_q;

endmodule

>>> rtl/core/sdlc_checker.sv
// ----------------------------------------------------------------------------
// sdlc_checker
// Port-level checks on the result channel of the coverage unit.
// ----------------------------------------------------------------------------
module sdlc_checker
  import sdlc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               draw_o,
  input logic [CovBits-1:0] coverage_o,
  input logic [31:0]        shaded_color_o
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(coverage_o)
      && $stable(shaded_color_o) && $stable(draw_o))
    else $error("stalled output word changed");

  a_cov_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> coverage_o <= CovBits'(CovFull))
    else $error("coverage above full scale");

  a_undrawn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !draw_o |-> coverage_o == '0 && shaded_color_o == '0)
    else $error("undrawn pixel carries data");

  a_full_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && draw_o && coverage_o == '0 |-> shaded_color_o[31:24] == '0)
    else $error("zero coverage with nonzero alpha");

endmodule

bind segment_distance_line_coverage sdlc_checker u_sdlc_checker (.*);
